// ----- design/ordered_list_engine_assert.svh -----
// Assertion macros for the ordered list engine.
// Both expect clk and rst_n in scope.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define OLE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define OLE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/oll_pkg.sv -----
package oll_pkg;

    localparam int DATA_W = 32;

    // Commands
    localparam logic [1:0] CMD_APPEND    = 2'd0;
    localparam logic [1:0] CMD_REM_MATCH = 2'd1;
    localparam logic [1:0] CMD_FIND      = 2'd2;
    localparam logic [1:0] CMD_REM_POS   = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] value;
        logic [3:0]               position;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] where_found;
        logic [4:0] entry_count;
    } res_item_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic load;   // write the incoming value
        logic shift;  // take a value from the chain
        logic wrap;   // take the head value rather than the right neighbour
    } cell_ctl_t;

endpackage

// ----- design/oll_cell.sv -----
module oll_cell
    import oll_pkg::*;
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] load_value,
    input  logic signed [DATA_W-1:0] neighbour,
    input  logic signed [DATA_W-1:0] head,
    output logic signed [DATA_W-1:0] value
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load)
        begin
            value_next = load_value;
        end
        else if (ctl.shift)
        begin
            // advance one place towards the head, or close the ring
            value_next = ctl.wrap ? head : neighbour;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- design/ordered_list_engine.sv -----
// Ordered list engine: a bounded list of signed 32-bit values kept in the
// order they were appended, held in a chain of CAPACITY cells.
// Command channel (cmd_valid / cmd_stall / cmd_data): a transfer carries
// cmd, value and position. Append, remove first match, find first match and
// remove at position are supported.
// Result channel (res_valid / res_stall / res_data): exactly one transfer per
// command, carrying status, where_found and entry_count, in command order.
// Append and any command that needs no search go straight to hand-over.
// Remove, find and remove-at-position on a list of n entries rotate the
// chain once round, one entry examined at the head cell per cycle, then
// hand over. A new command is taken in the cycle its predecessor hands
// over its result, as the result register loads in the hand-over cycle.
// Reset empties the list and the result register; cell contents are not
// cleared and are never read before being written.
// A stalled result is held in the result register; the engine still takes
// and completes one further command, then holds it and stalls the command
// channel until the result register drains.
`include "ordered_list_engine_assert.svh"

module ordered_list_engine
    import oll_pkg::*;
#(
    parameter int CAPACITY = 16
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd_data,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    logic [IDX_W-1:0]         step_reg, step_next;
    logic [IDX_W-1:0]         last_reg, last_next;
    logic [1:0]               op_reg, op_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [3:0]               pos_reg, pos_next;
    logic                     found_reg, found_next;
    logic [1:0]               status_reg, status_next;
    logic [IDX_W-1:0]         where_reg, where_next;
    logic                     res_valid_reg, res_valid_next;
    res_item_t                res_reg, res_next;

    logic                     take;
    logic                     out_free;
    logic                     out_load;
    logic                     append_go;
    logic                     hit;
    logic                     drop;
    logic [CNT_W-1:0]         occ_m1;
    logic signed [DATA_W-1:0] head;

    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    cell_ctl_t                cell_ctl   [CAPACITY];

    // Handshake: take a command when idle, or when the finished result
    // moves into the result register in this same cycle.
    assign out_free  = !res_valid_reg || !res_stall;
    assign out_load  = (state_reg == S_DONE) && out_free;
    assign cmd_stall = !((state_reg == S_IDLE) || out_load);
    assign take      = cmd_valid && !cmd_stall;
    assign append_go = take && (cmd_data.cmd == CMD_APPEND)
                       && (occ_reg != CNT_W'(CAPACITY));

    // Scan: the head cell holds the entry under test. Record the first
    // match; drop the head for a matching remove or the chosen position.
    assign head   = cell_value[0];
    assign occ_m1 = occ_reg - CNT_W'(1);
    assign hit    = (state_reg == S_SCAN) && (op_reg != CMD_REM_POS)
                    && !found_reg && (head == key_reg);
    assign drop   = (hit && (op_reg == CMD_REM_MATCH))
                    || ((state_reg == S_SCAN) && (op_reg == CMD_REM_POS)
                        && (CMP_W'(step_reg) == CMP_W'(pos_reg)));

    // Chain of cells. During a scan every cell takes its right neighbour;
    // the last occupied cell takes the head unless the head is being dropped,
    // so one full rotation restores order with the dropped entry closed up.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] right;

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right = head;
        end
        else
        begin : g_body
            assign right = cell_value[i+1];
        end

        assign cell_ctl[i].load  = append_go && (CNT_W'(i) == occ_reg);
        assign cell_ctl[i].shift = (state_reg == S_SCAN);
        assign cell_ctl[i].wrap  = (CNT_W'(i + 1) == occ_reg) && !drop;

        oll_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[i]),
            .load_value (cmd_data.value),
            .neighbour  (right),
            .head       (head),
            .value      (cell_value[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        where_next     = where_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        // Result register: load a finished result, or drain on transfer
        if (out_load)
        begin
            res_valid_next       = 1'b1;
            res_next.status      = status_reg;
            res_next.where_found = 4'(where_reg);
            res_next.entry_count = 5'(occ_reg);
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg) inside
            S_IDLE, S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
                if (take)
                begin
                    op_next     = cmd_data.cmd;
                    key_next    = cmd_data.value;
                    pos_next    = cmd_data.position;
                    step_next   = '0;
                    last_next   = occ_m1[IDX_W-1:0];
                    found_next  = 1'b0;
                    where_next  = '0;
                    status_next = STAT_MISS;
                    state_next  = S_DONE;
                    unique case (cmd_data.cmd) inside
                        CMD_APPEND:
                        begin
                            if (append_go)
                            begin
                                where_next  = occ_reg[IDX_W-1:0];
                                occ_next    = occ_reg + CNT_W'(1);
                                status_next = STAT_OK;
                            end
                            else
                            begin
                                status_next = STAT_FULL;
                            end
                        end
                        CMD_REM_MATCH, CMD_FIND:
                        begin
                            if (occ_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // remove at position: known good up front
                            if (CMP_W'(cmd_data.position) < CMP_W'(occ_reg))
                            begin
                                found_next = 1'b1;
                                where_next = IDX_W'(cmd_data.position);
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                step_next = step_reg + IDX_W'(1);
                if (hit)
                begin
                    found_next = 1'b1;
                    where_next = step_reg;
                end
                if (drop)
                begin
                    occ_next = occ_m1;
                end
                if (step_reg == last_reg)
                begin
                    state_next  = S_DONE;
                    status_next = (found_reg || hit) ? STAT_OK : STAT_MISS;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        last_reg   <= last_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        where_reg  <= where_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // The count never exceeds the chain length
    `OLE_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= CNT_W'(CAPACITY), "count above capacity")
    // A scan step removes at most one entry
    `OLE_ASSERT_NEXT(a_scan_drop, state_reg == S_SCAN, ($past(occ_reg) - occ_reg) <= CNT_W'(1), "scan removed more than one entry")
    // An accepted append with room grows the list by one
    `OLE_ASSERT_NEXT(a_append_grow, append_go, occ_reg == $past(occ_reg) + CNT_W'(1), "append did not grow list")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import oll_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int NUM_RANDOM = 500;
    localparam int MAX_REPORTS = 10;
    // Longest search is a full rotation plus the result register; allow some slack
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd_data = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res_data;

    // Shadow copy of the list, updated as each command transfer is taken
    logic signed [DATA_W-1:0] shadow_vals [LIST_DEPTH];
    int                       shadow_len = 0;

    cmd_item_t pending_cmds [$];
    res_item_t expected_results [$];
    int        fail_count = 0;

    // Sender burst shaping
    int burst_left = 0;
    int gap_left = 0;

    // Receiver stall pattern
    int stall_mode = 0;
    int stall_mode_left = 0;
    int cycle_ctr = 0;

    ordered_list_engine #(
        .CAPACITY (LIST_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #2 clk = ~clk;

    // Close up the gap left by the entry at idx
    function automatic void shadow_unlink(int idx);
        for (int i = idx; i + 1 < shadow_len; i++)
        begin
            shadow_vals[i] = shadow_vals[i + 1];
        end
        shadow_len--;
    endfunction

    // Apply one command to the shadow list and return the result it must give
    function automatic res_item_t apply_list_op(cmd_item_t op);
        res_item_t r;
        int        hit;
        r.status = STAT_MISS;
        r.where_found = '0;
        r.entry_count = '0;
        hit = -1;
        case (op.cmd)
            CMD_APPEND:
            begin
                if (shadow_len >= LIST_DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    shadow_vals[shadow_len] = op.value;
                    r.where_found = 4'(shadow_len);
                    shadow_len++;
                    r.status = STAT_OK;
                end
            end
            CMD_REM_MATCH, CMD_FIND:
            begin
                // Only the first match from the head counts
                for (int i = 0; i < shadow_len; i++)
                begin
                    if (hit < 0 && shadow_vals[i] == op.value)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    if (op.cmd == CMD_REM_MATCH)
                        shadow_unlink(hit);
                    r.where_found = 4'(hit);
                    r.status = STAT_OK;
                end
            end
            default:
            begin
                if (int'(op.position) < shadow_len)
                begin
                    shadow_unlink(int'(op.position));
                    r.where_found = op.position;
                    r.status = STAT_OK;
                end
            end
        endcase
        r.entry_count = 5'(shadow_len);
        return r;
    endfunction

    task automatic queue_cmd(logic [1:0] cmd, logic signed [DATA_W-1:0] value,
                             logic [3:0] position);
        cmd_item_t it;
        it.cmd = cmd;
        it.value = value;
        it.position = position;
        pending_cmds.push_back(it);
    endtask

    // Draw mostly from a small pool so that searches hit and duplicates occur
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] pool [8];
        pool[0] = 32'sh0000_0000;
        pool[1] = 32'shFFFF_FFFF;
        pool[2] = 32'sh0000_0001;
        pool[3] = 32'sh8000_0000;
        pool[4] = 32'sh7FFF_FFFF;
        pool[5] = 32'sh0000_0005;
        pool[6] = 32'sh5A5A_5A5A;
        pool[7] = 32'shA5A5_A5A5;
        if ($urandom_range(0, 9) < 7)
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Command driver: present the head of the pending queue, hold it while
    // stalled, and advance on each transfer. Gaps fall between bursts.
    always @(posedge clk)
    begin : cmd_driver
        bit took;
        took = 1'b0;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                expected_results.push_back(apply_list_op(cmd_data));
                void'(pending_cmds.pop_front());
                took = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    // Leave some bursts back to back so that long runs see no gap
                    gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                end
            end
            // Only change the payload once the current one has gone
            if (!cmd_valid || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd_valid <= 1'b1;
                    cmd_data  <= pending_cmds[0];
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: switch between free flow, light, heavy and
    // periodic stalling
    always @(posedge clk)
    begin : res_stall_gen
        cycle_ctr++;
        if (stall_mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(16, 64);
        end
        else
        begin
            stall_mode_left--;
        end
        case (stall_mode)
            0:       res_stall <= 1'b0;
            1:       res_stall <= ($urandom_range(0, 3) == 0);
            2:       res_stall <= ($urandom_range(0, 3) != 0);
            default: res_stall <= ((cycle_ctr % 8) < 5);
        endcase
    end

    // Result monitor: compare each transfer with the oldest expectation
    always @(posedge clk)
    begin : res_monitor
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result: status %0d where %0d count %0d",
                             res_data.status, res_data.where_found, res_data.entry_count);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_data.status !== want.status ||
                    res_data.where_found !== want.where_found ||
                    res_data.entry_count !== want.entry_count)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("mismatch: expected status %0d where %0d count %0d, got status %0d where %0d count %0d",
                                 want.status, want.where_found, want.entry_count,
                                 res_data.status, res_data.where_found,
                                 res_data.entry_count);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int phase_left;
        int bias;
        int roll;
        logic [1:0] cmd;

        // Directed: operations on an empty list
        queue_cmd(CMD_FIND, 32'sh0000_0007, 4'd0);
        queue_cmd(CMD_REM_MATCH, 32'sh0000_0007, 4'd0);
        queue_cmd(CMD_REM_POS, 32'sh0000_0000, 4'd0);
        // Fill to capacity with extremes and a duplicate pair
        queue_cmd(CMD_APPEND, 32'sh8000_0000, 4'd15);
        queue_cmd(CMD_APPEND, 32'sh7FFF_FFFF, 4'd0);
        queue_cmd(CMD_APPEND, 32'sh0000_0000, 4'd0);
        queue_cmd(CMD_APPEND, 32'shFFFF_FFFF, 4'd15);
        queue_cmd(CMD_APPEND, 32'sh0000_0007, 4'd0);
        queue_cmd(CMD_APPEND, 32'sh0000_0007, 4'd0);
        for (int i = 0; i < LIST_DEPTH - 6; i++)
        begin
            queue_cmd(CMD_APPEND, $urandom, 4'($urandom_range(0, 15)));
        end
        // Refused append, then duplicates: the head-most copy goes first
        queue_cmd(CMD_APPEND, 32'sh1234_5678, 4'd0);
        queue_cmd(CMD_FIND, 32'sh0000_0007, 4'd0);
        queue_cmd(CMD_REM_MATCH, 32'sh0000_0007, 4'd0);
        // Position at the count, then the tail, then the head
        queue_cmd(CMD_REM_POS, 32'sh0000_0000, 4'd15);
        queue_cmd(CMD_REM_POS, 32'sh0000_0000, 4'd14);
        queue_cmd(CMD_REM_POS, 32'sh0000_0000, 4'd0);

        // Random phases: append-heavy to reach full, balanced, remove-heavy to drain
        phase_left = 0;
        bias = 0;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(20, 60);
                bias = $urandom_range(0, 2);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            case (bias)
                0:       cmd = (roll < 70) ? CMD_APPEND : 2'($urandom_range(1, 3));
                1:       cmd = 2'($urandom_range(0, 3));
                default: cmd = (roll < 15) ? CMD_APPEND : 2'($urandom_range(1, 3));
            endcase
            queue_cmd(cmd, pick_value(),
                      ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                                   : 4'($urandom_range(0, 15)));
        end

        // Hold reset, then release
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
        begin
            $display("[ordered_list_engine] OK");
        end
        else
        begin
            $display("[ordered_list_engine] ERROR");
        end
        $finish;
    end

    // Drop the run if it hangs
    initial
    begin : watchdog
        #2000000;
        $display("[ordered_list_engine] ERROR");
        $finish;
    end

endmodule
